[rtl/core/tse_pkg.sv]
`timescale 1ns / 1ps

package tse_pkg;

  // Character codes used by the set notation
  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharDash      = 8'h2d;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharSeven     = 8'h37;
  localparam logic [7:0] CharNul       = 8'h00;

  // Most runs that one source byte can cause
  localparam int unsigned MaxRuns = 3;
  localparam int unsigned RunCntW = 2;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // One emitted run of codes
  typedef struct packed {
    logic       string_end;
    logic [7:0] final_code;
    logic [7:0] first_code;
  } run_t;

  // All runs caused by one source byte, in emission order
  typedef struct packed {
    logic [RunCntW-1:0]       cnt;
    run_t [MaxRuns-1:0]       runs;
  } job_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/core/tse_front.sv]
`timescale 1ns / 1ps

module tse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] src_byte
  input  tse_pkg::q_status_t q_status_i,
  output logic              push_o,
  output tse_pkg::job_t     push_job_o
);

  localparam logic [2:0] ModeIdle = 3'd0;
  localparam logic [2:0] ModeBsl  = 3'd1;
  localparam logic [2:0] ModeOct1 = 3'd2;
  localparam logic [2:0] ModeOct2 = 3'd3;
  localparam logic [2:0] ModeByte = 3'd4;
  localparam logic [2:0] ModeDash = 3'd5;

  logic [2:0]    mode_q, mode_d;
  logic [7:0]    held_q, held_d;
  logic          accept;
  logic          is_oct;
  logic          is_nul;
  logic [7:0]    oct_acc;
  logic          do_fresh;
  tse_pkg::job_t job;

  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_oct        = (s_axis_tdata >= tse_pkg::CharZero) &&
                         (s_axis_tdata <= tse_pkg::CharSeven);
  assign is_nul        = (s_axis_tdata == tse_pkg::CharNul);
  // Shift in one octal digit, keeping the low byte
  assign oct_acc       = {held_q[4:0], s_axis_tdata[2:0]};

  // Classify the byte against the pending context
  always_comb begin
    job      = '0;
    mode_d   = mode_q;
    held_d   = held_q;
    do_fresh = 1'b0;
    unique case (mode_q)
      ModeBsl: begin
        if (is_oct) begin
          held_d = {5'd0, s_axis_tdata[2:0]};
          mode_d = ModeOct1;
        end else if (is_nul) begin
          job.runs[0] = '{1'b0, tse_pkg::CharBackslash, tse_pkg::CharBackslash};
          job.runs[1] = '{1'b1, tse_pkg::CharNul, tse_pkg::CharNul};
          job.cnt     = 2'd2;
          mode_d      = ModeIdle;
        end else begin
          job.runs[0] = '{1'b0, s_axis_tdata, s_axis_tdata};
          job.cnt     = 2'd1;
          mode_d      = ModeIdle;
        end
      end
      ModeOct1: begin
        if (is_oct) begin
          held_d = oct_acc;
          mode_d = ModeOct2;
        end else begin
          job.runs[0] = '{1'b0, held_q, held_q};
          job.cnt     = 2'd1;
          do_fresh    = 1'b1;
        end
      end
      ModeOct2: begin
        if (is_oct) begin
          job.runs[0] = '{1'b0, oct_acc, oct_acc};
          job.cnt     = 2'd1;
          mode_d      = ModeIdle;
        end else begin
          job.runs[0] = '{1'b0, held_q, held_q};
          job.cnt     = 2'd1;
          do_fresh    = 1'b1;
        end
      end
      ModeByte: begin
        if (s_axis_tdata == tse_pkg::CharDash) begin
          mode_d = ModeDash;
        end else begin
          job.runs[0] = '{1'b0, held_q, held_q};
          job.cnt     = 2'd1;
          do_fresh    = 1'b1;
        end
      end
      ModeDash: begin
        if (is_nul) begin
          job.runs[0] = '{1'b0, held_q, held_q};
          job.runs[1] = '{1'b0, tse_pkg::CharDash, tse_pkg::CharDash};
          job.runs[2] = '{1'b1, tse_pkg::CharNul, tse_pkg::CharNul};
          job.cnt     = 2'd3;
        end else if (held_q <= s_axis_tdata) begin
          job.runs[0] = '{1'b0, s_axis_tdata, held_q};
          job.cnt     = 2'd1;
        end
        mode_d = ModeIdle;
      end
      default: do_fresh = 1'b1;
    endcase

    // Start over at a fresh position
    if (do_fresh) begin
      if (is_nul) begin
        if (job.cnt == 2'd0) begin
          job.runs[0] = '{1'b1, tse_pkg::CharNul, tse_pkg::CharNul};
        end else begin
          job.runs[1] = '{1'b1, tse_pkg::CharNul, tse_pkg::CharNul};
        end
        job.cnt = job.cnt + 2'd1;
        mode_d  = ModeIdle;
      end else if (s_axis_tdata == tse_pkg::CharBackslash) begin
        mode_d = ModeBsl;
      end else begin
        held_d = s_axis_tdata;
        mode_d = ModeByte;
      end
    end
  end

  // Advance the parse context on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      held_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

  // Queue only items that cause results
  assign push_o     = accept && (job.cnt != 2'd0);
  assign push_job_o = job;

endmodule

[rtl/core/tse_queue.sv]
`timescale 1ns / 1ps

module tse_queue #(
  parameter int unsigned Depth = tse_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tse_pkg::job_t      push_job_i,
  input  logic               pop_i,
  output tse_pkg::job_t      head_job_o,
  output tse_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tse_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign head_job_o     = mem_q[rd_ptr_q];

  // Store the job
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Move the pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overfill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!status_o.full || pop_i))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue read while empty");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue fill count out of range");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count failed to advance");

endmodule

[rtl/core/tse_back.sv]
`timescale 1ns / 1ps

module tse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tse_pkg::job_t      head_job_i,
  input  tse_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,  // [7:0] first_code, [15:8] final_code
  output logic [0:0]         m_axis_tuser,  // [0] string_end
  output logic               m_axis_tlast   // last_result
);

  logic [tse_pkg::RunCntW-1:0] idx_q;
  logic                        load;
  logic                        is_last;
  tse_pkg::run_t               run_sel;
  logic                        valid_q;
  tse_pkg::run_t               run_q;
  logic                        last_q;

  // Pick the run the index points at
  always_comb begin
    case (idx_q)
      2'd1:    run_sel = head_job_i.runs[1];
      2'd2:    run_sel = head_job_i.runs[2];
      default: run_sel = head_job_i.runs[0];
    endcase
  end

  assign is_last = (idx_q == head_job_i.cnt - 2'd1);
  assign load    = !q_status_i.empty && (!valid_q || m_axis_tready);
  assign pop_o   = load && is_last;

  // Step through the runs of the head job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= is_last ? '0 : idx_q + 2'd1;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Hold the output beat until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      run_q  <= run_sel;
      last_q <= is_last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {run_q.final_code, run_q.first_code};
  assign m_axis_tuser  = run_q.string_end;
  assign m_axis_tlast  = last_q;

  a_idx_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status_i.empty |-> (idx_q == '0))
    else $error("run index not at start with no job pending");

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> (idx_q < head_job_i.cnt))
    else $error("run index beyond job run count");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && run_sel.string_end) |-> is_last)
    else $error("terminator run not last of its job");

endmodule

[rtl/core/tr_set_notation_expander.sv]
`timescale 1ns / 1ps

// Expands tr-style set notation, one source byte per beat, into runs of codes.
// Slave channel: s_axis_tdata carries one source byte; a zero byte ends the
// string. Master channel: each beat is one run, first_code in tdata[7:0] and
// final_code (inclusive) in tdata[15:8]; tuser[0] marks the terminator run of a
// string and tlast marks the final run caused by one source byte. Bytes that
// only update the parse context (backslash, octal digits, a held range start,
// a range dash) or that close an empty range produce no beat.
// A run reaches the master side through the job queue and then the output register.
// Throughput: one source byte per cycle and, while the receiver is ready, one
// run per cycle. A byte can cause up to three runs; the output stage drains them
// one per cycle while the job queue keeps taking bytes, so the input stalls only
// when the queue is full. Reset clears the parse context to idle, empties the
// queue and drops any beat held at the output. When the receiver stalls the
// current beat is held and the queue fills; s_axis_tready falls once it is full.
module tr_set_notation_expander #(
  parameter int unsigned QueueDepth = tse_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] src_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] first_code, [15:8] final_code
  output logic [0:0]  m_axis_tuser,   // [0] string_end
  output logic        m_axis_tlast    // last_result
);

  tse_pkg::q_status_t q_status;
  tse_pkg::job_t      push_job;
  tse_pkg::job_t      head_job;
  logic               push;
  logic               pop;

  tse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_job_o    (push_job)
  );

  tse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .status_o   (q_status)
  );

  tse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_job_i    (head_job),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
